FILE: hdl/scc_pkg.sv
// Shared types and constants of the speed cruise controller.
// Used by scc_div and speed_cruise_controller; depends on nothing else.
package scc_pkg;

	localparam int ERR_W     = 16;
	localparam int MUL_CNT_W = $clog2(ERR_W);

	// Time step: dt = min(elapsed / 40, 25) in fixed point.
	localparam logic [5:0]  DT_DIV     = 6'd40;
	localparam logic [4:0]  DT_MAX     = 5'd25;
	localparam logic [15:0] DT_SAT_MS  = 16'd1000;   // 40 * 25: dt saturates from here
	localparam int          DT_MS_BITS = 10;         // elapsed below saturation fits here

	localparam logic [6:0]         LOSS_SCALE = 7'd100;
	localparam logic signed [15:0] STALL_RPM  = 16'sd10;
	localparam logic signed [15:0] RESUME_RPM = 16'sd100;
	localparam logic [7:0]         NEUTRAL    = 8'd90;

	typedef enum logic [2:0] {
		CFG_TARGET  = 3'd0,
		CFG_GAIN    = 3'd1,
		CFG_LOSS    = 3'd2,
		CFG_LOW     = 3'd3,
		CFG_HIGH    = 3'd4,
		CFG_CONTROL = 3'd5
	} cfg_idx_t;

	// Which of the three divisions the shared divider runs.
	typedef enum logic [1:0] {
		DIV_DT,
		DIV_PROD,
		DIV_DRIVE
	} div_kind_t;

	typedef struct packed {
		logic      start;
		div_kind_t kind;
	} div_req_t;

	typedef struct packed {
		logic [15:0]        elapsed_ms;
		logic signed [15:0] measured_rpm;
	} in_item_t;

	typedef struct packed {
		logic [7:0] drive_angle;
		logic       stalled;
	} out_item_t;

endpackage

FILE: hdl/scc_div.sv
// Bit-serial restoring divider shared by the three divisions of one item.
// Depends on scc_pkg for the request struct and division kinds.
module scc_div #(
	parameter int FRAC_BITS = 16,
	localparam int W   = 8 + FRAC_BITS,
	localparam int PW  = 21 + FRAC_BITS,
	localparam int DW  = PW + 1,
	localparam int NW  = (W + FRAC_BITS > PW) ? W + FRAC_BITS : PW,
	localparam int DTW = scc_pkg::DT_MS_BITS + FRAC_BITS,
	localparam int CW  = $clog2(NW + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scc_pkg::div_req_t     req,
	input  logic [NW-1:0]         num,
	input  logic [DW-1:0]         den,
	output logic                  done,
	output logic [NW-1:0]         quo
);

	localparam int SH_DT    = NW - DTW;
	localparam int SH_PROD  = NW - PW;
	localparam int SH_DRIVE = NW - (W + FRAC_BITS);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;

	logic [DW:0] trial;
	logic [DW:0] trial_sub;
	logic        ge;

	// The numerator is left-aligned so that only its significant bits are
	// walked; the quotient shifts in from the bottom of the same register.
	assign trial     = {rem_q, quo_q[NW-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign ge        = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				case (req.kind)
					scc_pkg::DIV_DT:   cnt_q <= CW'(DTW);
					scc_pkg::DIV_PROD: cnt_q <= CW'(PW);
					default:           cnt_q <= CW'(W + FRAC_BITS);
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= den;
			case (req.kind)
				scc_pkg::DIV_DT:   quo_q <= num << SH_DT;
				scc_pkg::DIV_PROD: quo_q <= num << SH_PROD;
				default:           quo_q <= num << SH_DRIVE;
			endcase
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: hdl/speed_cruise_controller.sv
// Top level of the speed cruise controller: configuration, sequencer and output register.
// Depends on scc_pkg and on the shared serial divider scc_div.
//
// One input item is one update tick. While control is on, the block forms a
// time step from the elapsed milliseconds, raises or divides down its drive
// level by the speed error, clamps it to [drive_low, drive_high], updates the
// stall latch and delivers one result item; while control is off an item is
// accepted and dropped without a result. Items are handled one at a time:
// in_stall is high from acceptance until the result is loaded into the output
// register. All arithmetic runs through one bit-serial restoring divider (one
// quotient bit per cycle) and a shift-add multiplier (one error bit per
// cycle). A tick with equal speeds skips the time step, the multiply and the
// divisions and goes straight to the clamp. From 1000 ms on the time step
// saturates and its division is skipped; a downward step runs one division
// more than an upward step, and the emit state waits while the output stalls.
module speed_cruise_controller #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  scc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output scc_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [15:0]         cfg_data
);

	// Drive level is Q8.F; the product dt*err needs 21+F bits and the
	// downward denominator one more.
	localparam int W    = 8 + FRAC_BITS;
	localparam int PW   = 21 + FRAC_BITS;
	localparam int DW   = PW + 1;
	localparam int NW   = (W + FRAC_BITS > PW) ? W + FRAC_BITS : PW;
	localparam int DTQW = 5 + FRAC_BITS;
	localparam int MCW  = scc_pkg::MUL_CNT_W;

	localparam logic [W-1:0]    Q_NEUTRAL = {scc_pkg::NEUTRAL, {FRAC_BITS{1'b0}}};
	localparam logic [W-1:0]    Q_MAX     = '1;
	localparam logic [DTQW-1:0] DT_SAT    = {scc_pkg::DT_MAX, {FRAC_BITS{1'b0}}};
	localparam logic [DW-1:0]   Q_ONE     = DW'(1) << FRAC_BITS;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DT_GO,
		ST_DT_WAIT,
		ST_MUL,
		ST_P_GO,
		ST_P_WAIT,
		ST_D_GO,
		ST_D_WAIT,
		ST_CLAMP,
		ST_EMIT
	} state_t;

	// Configuration registers.
	logic signed [15:0] target_q;
	logic [15:0]        gain_q;
	logic [15:0]        loss_q;
	logic [7:0]         low_q;
	logic [7:0]         high_q;
	logic               ctrl_on_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			gain_q    <= 16'd160;
			loss_q    <= 16'd100;
			low_q     <= 8'd90;
			high_q    <= 8'd180;
			ctrl_on_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				scc_pkg::CFG_TARGET:  target_q  <= cfg_data;
				scc_pkg::CFG_GAIN:    gain_q    <= cfg_data;
				scc_pkg::CFG_LOSS:    loss_q    <= cfg_data;
				scc_pkg::CFG_LOW:     low_q     <= cfg_data[7:0];
				scc_pkg::CFG_HIGH:    high_q    <= cfg_data[7:0];
				scc_pkg::CFG_CONTROL: ctrl_on_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer state, loop state and the output register.
	state_t                 state_q;
	logic [W-1:0]           drive_q;
	logic                   stall_q;
	logic signed [15:0]     rpm_q;
	logic [scc_pkg::DT_MS_BITS-1:0] el_q;
	logic                   up_q;
	logic [PW-1:0]          acc_q;
	logic [PW-1:0]          mcand_q;
	logic [scc_pkg::ERR_W-1:0] mplier_q;
	logic [MCW-1:0]         mcnt_q;
	logic [DW-1:0]          denom_q;
	logic                   out_valid_q;
	scc_pkg::out_item_t     out_data_q;

	// Divider hookup.
	scc_pkg::div_req_t div_req;
	logic [NW-1:0]     div_num;
	logic [DW-1:0]     div_den;
	logic              div_done;
	logic [NW-1:0]     div_quo;

	scc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// A zero divisor counts as one.
	logic [15:0]   gain_eff;
	logic [15:0]   loss_eff;
	logic [DW-1:0] loss_scaled;

	assign gain_eff    = (gain_q == '0) ? 16'd1 : gain_q;
	assign loss_eff    = (loss_q == '0) ? 16'd1 : loss_q;
	assign loss_scaled = DW'(loss_eff) * DW'(scc_pkg::LOSS_SCALE);

	always_comb begin
		div_req.start = 1'b0;
		div_req.kind  = scc_pkg::DIV_DRIVE;
		div_num       = NW'({drive_q, {FRAC_BITS{1'b0}}});
		div_den       = denom_q;
		case (state_q)
			ST_DT_GO: begin
				div_req.start = 1'b1;
				div_req.kind  = scc_pkg::DIV_DT;
				div_num       = NW'({el_q, {FRAC_BITS{1'b0}}});
				div_den       = DW'(scc_pkg::DT_DIV);
			end
			ST_P_GO: begin
				div_req.start = 1'b1;
				div_req.kind  = scc_pkg::DIV_PROD;
				div_num       = NW'(acc_q);
				div_den       = up_q ? DW'(gain_eff) : loss_scaled;
			end
			ST_D_GO: begin
				div_req.start = 1'b1;
			end
			default: ;
		endcase
	end

	// Speed error of the incoming item, exact over the full 16-bit range.
	logic signed [16:0] diff_in;
	logic [15:0]        err_in;
	logic               resume_in;

	assign diff_in   = $signed({target_q[15], target_q})
		- $signed({in_data.measured_rpm[15], in_data.measured_rpm});
	assign err_in    = diff_in[16] ? 16'(17'd0 - diff_in) : diff_in[15:0];
	assign resume_in = (in_data.measured_rpm > scc_pkg::RESUME_RPM) && stall_q;

	// Upward step saturates at the top of the Q8.F range.
	logic [PW:0]  sum_up;
	logic [W-1:0] hi_lvl;
	logic [W-1:0] lo_lvl;

	assign sum_up = (PW+1)'(drive_q) + (PW+1)'(div_quo[PW-1:0]);
	assign hi_lvl = {high_q, {FRAC_BITS{1'b0}}};
	assign lo_lvl = {low_q, {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			drive_q     <= Q_NEUTRAL;
			stall_q     <= 1'b0;
			rpm_q       <= '0;
			el_q        <= '0;
			up_q        <= 1'b0;
			acc_q       <= '0;
			mcand_q     <= '0;
			mplier_q    <= '0;
			mcnt_q      <= '0;
			denom_q     <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// The emit state hands over the output register itself.
			if (out_valid_q && !out_stall && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					// With control off the item is simply dropped.
					if (in_valid && ctrl_on_q) begin
						rpm_q    <= in_data.measured_rpm;
						el_q     <= in_data.elapsed_ms[scc_pkg::DT_MS_BITS-1:0];
						up_q     <= !diff_in[16];
						mplier_q <= err_in;
						acc_q    <= '0;
						mcnt_q   <= '0;
						mcand_q  <= PW'(DT_SAT);
						if (resume_in) begin
							stall_q <= 1'b0;
							drive_q <= Q_NEUTRAL;
						end
						if (diff_in == '0) begin
							state_q <= ST_CLAMP;
						end else if (in_data.elapsed_ms >= scc_pkg::DT_SAT_MS) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_DT_GO;
						end
					end
				end
				ST_DT_GO: begin
					state_q <= ST_DT_WAIT;
				end
				ST_DT_WAIT: begin
					if (div_done) begin
						mcand_q <= PW'(div_quo[DTQW-1:0]);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// One error bit per cycle, least significant first.
					if (mplier_q[0]) begin
						acc_q <= acc_q + mcand_q;
					end
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					mcnt_q   <= mcnt_q + MCW'(1);
					if (mcnt_q == MCW'(scc_pkg::ERR_W - 1)) begin
						state_q <= ST_P_GO;
					end
				end
				ST_P_GO: begin
					state_q <= ST_P_WAIT;
				end
				ST_P_WAIT: begin
					if (div_done) begin
						if (up_q) begin
							drive_q <= (sum_up > (PW+1)'(Q_MAX)) ? Q_MAX : sum_up[W-1:0];
							state_q <= ST_CLAMP;
						end else begin
							denom_q <= Q_ONE + DW'(div_quo[PW-1:0]);
							state_q <= ST_D_GO;
						end
					end
				end
				ST_D_GO: begin
					state_q <= ST_D_WAIT;
				end
				ST_D_WAIT: begin
					// The denominator is at least one, so the result fits the level.
					if (div_done) begin
						drive_q <= div_quo[W-1:0];
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					// The upper bound is tested first; with crossed bounds a level below it still goes to the lower one.
					if (drive_q >= hi_lvl) begin
						drive_q <= hi_lvl;
						if (rpm_q < scc_pkg::STALL_RPM) begin
							stall_q <= 1'b1;
						end
					end else if (drive_q < lo_lvl) begin
						drive_q <= lo_lvl;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q            <= 1'b1;
						out_data_q.drive_angle <= stall_q ? scc_pkg::NEUTRAL
							: drive_q[W-1 -: 8];
						out_data_q.stalled     <= stall_q;
						state_q                <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A stalled result always carries the neutral drive value.
	a_stall_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.stalled) |-> (out_data.drive_angle == scc_pkg::NEUTRAL))
		else $error("stalled result without neutral drive");

	// The divider only finishes while the sequencer waits for it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DT_WAIT || state_q == ST_P_WAIT
			|| state_q == ST_D_WAIT))
		else $error("divider finished outside a wait state");

	// A new result is only ever loaded from the emit state.
	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_EMIT))
		else $error("result appeared outside the emit state");

endmodule
